// File: design/keypad_passcode_lock_unit_macros.svh
// ----------------------------------------------------------------------------
// keypad passcode lock assertion macros
// shared property forms used by the lock's concurrent checks
// ----------------------------------------------------------------------------
`ifndef KEYPAD_PASSCODE_LOCK_UNIT_MACROS_SVH
`define KEYPAD_PASSCODE_LOCK_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define KPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KPL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/kpl_pkg.sv
// ----------------------------------------------------------------------------
// kpl_pkg
// types and constants for the keypad passcode lock
// ----------------------------------------------------------------------------
package kpl_pkg;

    localparam int KEY_W      = 8;
    localparam int ST_W       = 3;
    localparam int DCNT_W     = 3;
    localparam int NIB_W      = 4;
    localparam int SECRET_W   = 24;
    localparam int SECRET_NIB = SECRET_W / NIB_W;
    localparam int MISS_W     = 4;
    localparam int CD_W       = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [ST_W-1:0] status_t;

    localparam status_t ST_OK            = 3'd0;
    localparam status_t ST_INCOMPLETE    = 3'd1;
    localparam status_t ST_INVALID       = 3'd2;
    localparam status_t ST_VALID         = 3'd3;
    localparam status_t ST_COOLDOWN      = 3'd4;
    localparam status_t ST_REQUIRE_RESET = 3'd5;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
    localparam logic [KEY_W-1:0] KEY_NINE = 8'h39;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_SECRET    = 3'd0;
    localparam cfg_idx_t CFG_POP_KEY   = 3'd1;
    localparam cfg_idx_t CFG_VAL_KEY   = 3'd2;
    localparam cfg_idx_t CFG_MAX_MISS  = 3'd3;
    localparam cfg_idx_t CFG_COOLDOWN  = 3'd4;

    localparam logic [KEY_W-1:0]  RST_POP_KEY  = 8'd42;
    localparam logic [KEY_W-1:0]  RST_VAL_KEY  = 8'd35;
    localparam logic [MISS_W-1:0] RST_MAX_MISS = 4'd3;
    localparam logic [CD_W-1:0]   RST_COOLDOWN = 32'd30;

endpackage

// File: design/keypad_passcode_lock_unit.sv
// ----------------------------------------------------------------------------
// keypad passcode lock unit
// Keypad combination lock with a miss counter, a cooldown and a final
// lockout. Each input beat is either a key press or one tick of time; every
// key press gives exactly one result beat (status, digits held, lock flag),
// ticks give none and only advance a running cooldown. One beat is taken
// every clock cycle while no key beat waits on the result side. A beat is
// held in the input register; its whole state update (entry buffer, digit
// compare, miss and cooldown counters) is one combinational pass into the
// result register that offers a key's result. The result register stalls only
// key beats when the result side holds off; ticks pass through regardless.
// Configuration is written through cfg_we / cfg_index / cfg_wdata.
// ----------------------------------------------------------------------------
`include "keypad_passcode_lock_unit_macros.svh"

module keypad_passcode_lock_unit #(
    parameter int DIGITS = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_we,
    input  logic [kpl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kpl_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [kpl_pkg::KEY_W-1:0]      s_key_code,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [kpl_pkg::ST_W-1:0]       m_status,
    output logic [kpl_pkg::DCNT_W-1:0]     m_digits_entered,
    output logic                           m_locked
);
    import kpl_pkg::*;

    localparam int CNT_W = $clog2(DIGITS + 1);
    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // configuration
    logic [SECRET_W-1:0] secret_reg;
    logic [KEY_W-1:0]    pop_key_reg;
    logic [KEY_W-1:0]    val_key_reg;
    logic [MISS_W-1:0]   max_miss_reg;
    logic [CD_W-1:0]     cd_ticks_reg;

    // input stage
    logic             in_valid_reg;
    logic             cmd_reg;
    logic [KEY_W-1:0] key_reg;

    // lock state
    logic [NIB_W-1:0]  entry_store_reg [DIGITS];
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [MISS_W-1:0] miss_count_reg, miss_count_next;
    logic              cd_started_reg, cd_started_next;
    logic [CD_W-1:0]   cd_elapsed_reg, cd_elapsed_next;
    logic              lockout_reg, lockout_next;

    // result stage
    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [DCNT_W-1:0] m_digits_reg;
    logic              m_locked_reg;

    logic              advance;
    status_t           status_next;
    logic              store_we;
    logic [IDX_W-1:0]  store_idx;
    logic [NIB_W-1:0]  store_digit;
    logic [KEY_W-1:0]  key_sub;
    logic [MISS_W-1:0] miss_inc;
    logic              entry_full;
    logic              entry_match;
    logic [NIB_W-1:0]  secret_nib [DIGITS];
    logic [CNT_W+DCNT_W-1:0] cnt_ext;

    // key items wait on the result register, ticks never do
    assign advance = in_valid_reg & ((cmd_reg == CMD_TICK) | ~m_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secret_reg   <= '0;
            pop_key_reg  <= RST_POP_KEY;
            val_key_reg  <= RST_VAL_KEY;
            max_miss_reg <= RST_MAX_MISS;
            cd_ticks_reg <= RST_COOLDOWN;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SECRET:   secret_reg   <= cfg_wdata[SECRET_W-1:0];
                CFG_POP_KEY:  pop_key_reg  <= cfg_wdata[KEY_W-1:0];
                CFG_VAL_KEY:  val_key_reg  <= cfg_wdata[KEY_W-1:0];
                CFG_MAX_MISS: max_miss_reg <= cfg_wdata[MISS_W-1:0];
                CFG_COOLDOWN: cd_ticks_reg <= cfg_wdata[CD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_cmd;
            key_reg <= s_key_code;
        end
    end

    // secret digits past the packed field compare against zero
    for (genvar i = 0; i < DIGITS; i++) begin : g_secret
        if (i < SECRET_NIB) begin : g_in
            assign secret_nib[i] = secret_reg[NIB_W*i +: NIB_W];
        end else begin : g_out
            assign secret_nib[i] = '0;
        end
    end

    always_comb begin
        entry_match = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (entry_store_reg[i] != secret_nib[i]) begin
                entry_match = 1'b0;
            end
        end
    end

    assign entry_full  = (entry_count_reg == CNT_W'(DIGITS));
    assign key_sub     = key_reg - KEY_ZERO;
    assign store_digit = key_sub[NIB_W-1:0];
    assign store_idx   = entry_count_reg[IDX_W-1:0];
    assign miss_inc    = miss_count_reg + MISS_W'(1);

    always_comb begin
        entry_count_next = entry_count_reg;
        miss_count_next  = miss_count_reg;
        cd_started_next  = cd_started_reg;
        cd_elapsed_next  = cd_elapsed_reg;
        lockout_next     = lockout_reg;
        status_next      = ST_OK;
        store_we         = 1'b0;
        if (advance) begin
            if (cmd_reg == CMD_TICK) begin
                if (cd_started_reg && (cd_elapsed_reg != '1)) begin
                    cd_elapsed_next = cd_elapsed_reg + CD_W'(1);
                end
            end else begin
                priority if (key_reg == pop_key_reg) begin
                    if (entry_count_reg != '0) begin
                        entry_count_next = entry_count_reg - CNT_W'(1);
                    end
                end else if (key_reg == val_key_reg) begin
                    priority if (lockout_reg) begin
                        entry_count_next = '0;
                        status_next      = ST_REQUIRE_RESET;
                    end else if (cd_started_reg && (cd_elapsed_reg < cd_ticks_reg)) begin
                        entry_count_next = '0;
                        status_next      = ST_COOLDOWN;
                    end else if (!entry_full) begin
                        status_next = ST_INCOMPLETE;
                    end else begin
                        entry_count_next = '0;
                        if (entry_match) begin
                            status_next     = ST_VALID;
                            miss_count_next = '0;
                            cd_started_next = 1'b0;
                            cd_elapsed_next = '0;
                        end else if (cd_started_reg) begin
                            // wrong final try after the cooldown
                            status_next  = ST_INVALID;
                            lockout_next = 1'b1;
                        end else begin
                            status_next     = ST_INVALID;
                            miss_count_next = miss_inc;
                            if (miss_inc == max_miss_reg) begin
                                cd_started_next = 1'b1;
                                cd_elapsed_next = '0;
                            end
                        end
                    end
                end else if ((key_reg >= KEY_ZERO) && (key_reg <= KEY_NINE)) begin
                    if (!entry_full) begin
                        store_we         = 1'b1;
                        entry_count_next = entry_count_reg + CNT_W'(1);
                    end
                end else begin
                    status_next = ST_OK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            entry_store_reg[store_idx] <= store_digit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            miss_count_reg  <= '0;
            cd_started_reg  <= 1'b0;
            cd_elapsed_reg  <= '0;
            lockout_reg     <= 1'b0;
        end else begin
            entry_count_reg <= entry_count_next;
            miss_count_reg  <= miss_count_next;
            cd_started_reg  <= cd_started_next;
            cd_elapsed_reg  <= cd_elapsed_next;
            lockout_reg     <= lockout_next;
        end
    end

    assign cnt_ext = {{DCNT_W{1'b0}}, entry_count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && (cmd_reg == CMD_KEY)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (cmd_reg == CMD_KEY)) begin
            m_status_reg <= status_next;
            m_digits_reg <= cnt_ext[DCNT_W-1:0];
            m_locked_reg <= lockout_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_digits_entered = m_digits_reg;
    assign m_locked         = m_locked_reg;

    `KPL_ASSERT_NXT(a_lockout_sticks, aclk, aresetn, lockout_reg, lockout_reg,
        "lockout cleared without reset")
    `KPL_ASSERT_IMP(a_elapsed_only_in_cooldown, aclk, aresetn, cd_elapsed_reg != '0,
        cd_started_reg, "cooldown ticks counted with no cooldown running")
    `KPL_ASSERT_IMP(a_reset_status_locked, aclk, aresetn,
        m_valid_reg && (m_status_reg == ST_REQUIRE_RESET), m_locked_reg,
        "require-reset reported while not locked")
    `KPL_ASSERT_IMP(a_answer_clears_entry, aclk, aresetn,
        m_valid_reg && ((m_status_reg == ST_VALID) || (m_status_reg == ST_INVALID) ||
        (m_status_reg == ST_COOLDOWN) || (m_status_reg == ST_REQUIRE_RESET)),
        m_digits_reg == '0, "validate answer left digits in the entry")

endmodule

// File: sim/tb_keypad_passcode_lock_unit.sv
// ----------------------------------------------------------------------------
// tb_keypad_passcode_lock_unit
// Self-checking bench for the keypad passcode lock. Key and tick beats come
// from a pending queue through a bursty driver, and a lock model predicts one
// answer per key press. The monitor compares every result beat with the oldest
// prediction, field by field. The run starts with hand-picked keys under the
// reset settings. It then goes through six register settings, with entry
// attempts built around the live lock state, so that misses, cooldowns and
// final tries are reached and the permanent lockout comes in the last one.
// ----------------------------------------------------------------------------
module tb_keypad_passcode_lock_unit;
    import kpl_pkg::*;

    localparam int N_DIGITS     = 6;
    localparam int LIMIT_CYCLES = 500000;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
    } press_t;

    typedef struct packed {
        status_t           status;
        logic [DCNT_W-1:0] digits;
        logic              locked;
    } lock_answer_t;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic                  s_cmd      = CMD_KEY;
    logic [KEY_W-1:0]      s_key_code = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [ST_W-1:0]       m_status;
    logic [DCNT_W-1:0]     m_digits_entered;
    logic                  m_locked;

    keypad_passcode_lock_unit #(
        .DIGITS(N_DIGITS)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_key_code      (s_key_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_digits_entered(m_digits_entered),
        .m_locked        (m_locked)
    );

    always #4 aclk = ~aclk;

    // lock model: register copies and state
    logic [SECRET_W-1:0] sec_code   = '0;
    logic [KEY_W-1:0]    pop_code   = RST_POP_KEY;
    logic [KEY_W-1:0]    enter_code = RST_VAL_KEY;
    logic [MISS_W-1:0]   miss_limit = RST_MAX_MISS;
    logic [CD_W-1:0]     cd_len     = RST_COOLDOWN;
    logic [NIB_W-1:0]    entry [N_DIGITS];
    int                  held       = 0;
    logic [MISS_W-1:0]   misses     = '0;
    logic                cd_running = 1'b0;
    logic [CD_W-1:0]     cd_elapsed = '0;
    logic                locked_out = 1'b0;

    press_t       press_q[$];
    lock_answer_t answer_q[$];

    int  err_count   = 0;
    int  checked     = 0;
    int  items_sent  = 0;
    int  phases      = 0;
    int  cycles      = 0;
    int  st_seen [6] = '{default: 0};
    logic s_taken    = 1'b0;
    int  burst_left  = 0;
    int  gap_left    = 0;
    logic [8:0] stall_phase = '0;

    function automatic status_t judge_entry();
        bit hit;
        hit = 1'b1;
        if (locked_out) begin
            held = 0;
            return ST_REQUIRE_RESET;
        end
        if (cd_running && cd_elapsed < cd_len) begin
            held = 0;
            return ST_COOLDOWN;
        end
        if (held != N_DIGITS)
            return ST_INCOMPLETE;
        for (int i = 0; i < N_DIGITS; i++) begin
            // nibbles above 9 can never be typed, so they never match
            if (entry[i] != ((i < SECRET_NIB) ? sec_code[NIB_W*i +: NIB_W] : '0))
                hit = 1'b0;
        end
        held = 0;
        if (hit) begin
            cd_running = 1'b0;
            cd_elapsed = '0;
            misses     = '0;
            return ST_VALID;
        end
        if (cd_running) begin
            // miss on the last try after the cooldown
            locked_out = 1'b1;
        end else begin
            misses = misses + 1'b1;
            if (misses == miss_limit) begin
                cd_running = 1'b1;
                cd_elapsed = '0;
            end
        end
        return ST_INVALID;
    endfunction

    task automatic advance_lock(input logic cmd, input logic [KEY_W-1:0] key);
        status_t      st;
        lock_answer_t ans;
        st = ST_OK;
        if (cmd == CMD_TICK) begin
            if (cd_running && cd_elapsed != '1)
                cd_elapsed = cd_elapsed + 1'b1;
        end else begin
            if (key == pop_code) begin
                if (held > 0)
                    held--;
            end else if (key == enter_code) begin
                st = judge_entry();
            end else if (key >= KEY_ZERO && key <= KEY_NINE) begin
                if (held < N_DIGITS) begin
                    entry[held] = NIB_W'(key - KEY_ZERO);
                    held++;
                end
            end
            ans.status = st;
            ans.digits = DCNT_W'(held);
            ans.locked = locked_out;
            answer_q.push_back(ans);
            st_seen[st]++;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 40)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        err_count++;
    endtask

    // monitor: result check, input acceptance and prediction, watchdog
    always @(posedge aclk) begin : monitor
        lock_answer_t want;
        cycles++;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("result beat with nothing pending", m_status, -1);
                end else begin
                    want = answer_q.pop_front();
                    checked++;
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_digits_entered !== want.digits)
                        report_mismatch("digits_entered", m_digits_entered, want.digits);
                    if (m_locked !== want.locked)
                        report_mismatch("locked", m_locked, want.locked);
                end
            end
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready)
                advance_lock(s_cmd, s_key_code);
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("watchdog expired, %0d results still pending", answer_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // driver: bursts of beats with random gaps in between
    always @(negedge aclk) begin : driver
        press_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (press_q.size() > 0) begin
                nxt = press_q.pop_front();
                s_valid    <= 1'b1;
                s_cmd      <= nxt.cmd;
                s_key_code <= nxt.key;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: the stall style changes with the top two bits of stall_phase
    always @(negedge aclk) begin : stall_gen
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[8:7])
            2'd0: begin
                m_ready <= 1'b1;
            end
            2'd1: begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end
            2'd2: begin
                m_ready <= (stall_phase[2:0] > 3'd2);
            end
            default: begin
                m_ready <= (stall_phase[5:4] != 2'd0);
            end
        endcase
    end

    task automatic push_beat(input logic cmd, input logic [KEY_W-1:0] key);
        press_t p;
        p.cmd = cmd;
        p.key = key;
        press_q.push_back(p);
        items_sent++;
    endtask

    task automatic push_digit(input int d);
        push_beat(CMD_KEY, KEY_ZERO + KEY_W'(d));
    endtask

    // a key that is neither a digit nor one of the two control codes
    function automatic logic [KEY_W-1:0] stray_key();
        logic [KEY_W-1:0] k;
        do begin
            k = KEY_W'($urandom);
        end while ((k >= KEY_ZERO && k <= KEY_NINE) || k == pop_code || k == enter_code);
        return k;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_bcd();
        logic [CFG_DATA_W-1:0] v;
        v = '0;
        for (int i = 0; i < SECRET_NIB; i++)
            v[NIB_W*i +: NIB_W] = NIB_W'($urandom_range(0, 9));
        return v;
    endfunction

    // every accepted beat has gone through the model
    task automatic wait_sent();
        do @(posedge aclk); while (press_q.size() != 0 || s_valid);
    endtask

    task automatic wait_results();
        do @(posedge aclk); while (press_q.size() != 0 || s_valid || answer_q.size() != 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_SECRET:   sec_code   = val[SECRET_W-1:0];
            CFG_POP_KEY:  pop_code   = val[KEY_W-1:0];
            CFG_VAL_KEY:  enter_code = val[KEY_W-1:0];
            CFG_MAX_MISS: miss_limit = val[MISS_W-1:0];
            CFG_COOLDOWN: cd_len     = val[CD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_phase(input logic [CFG_DATA_W-1:0] sec, input logic [KEY_W-1:0] pop,
                             input logic [KEY_W-1:0] ent, input logic [MISS_W-1:0] mx,
                             input logic [CD_W-1:0] cd);
        wait_results();
        // tick beats give no result, let any still in the pipe drain
        repeat (6) @(negedge aclk);
        write_reg(CFG_SECRET, sec);
        write_reg(CFG_POP_KEY, CFG_DATA_W'(pop));
        write_reg(CFG_VAL_KEY, CFG_DATA_W'(ent));
        write_reg(CFG_MAX_MISS, CFG_DATA_W'(mx));
        write_reg(CFG_COOLDOWN, cd);
        @(negedge aclk);
        cfg_we <= 1'b0;
        phases++;
    endtask

    // one round of stimulus, shaped by the current lock state
    task automatic push_round(input int miss_pct, input bit may_lock);
        int   pick;
        int   n;
        bit   last_try;
        bit   can_match;
        bit   good;
        longint left;
        logic [NIB_W-1:0] d;
        last_try  = cd_running && cd_elapsed >= cd_len && !locked_out;
        can_match = 1'b1;
        for (int i = 0; i < SECRET_NIB; i++)
            if (sec_code[NIB_W*i +: NIB_W] > 4'd9)
                can_match = 1'b0;
        pick = $urandom_range(0, 99);
        if (last_try && !may_lock && !can_match)
            pick = 10;
        else if (last_try && !may_lock)
            pick = 99;
        left = longint'(cd_len) - longint'(cd_elapsed);
        if (cd_running && left > 0 && !locked_out && pick < 55) begin
            // push the cooldown along, sometimes past its end
            n = (left <= 40) ? int'(left) + $urandom_range(0, 2) : $urandom_range(1, 6);
            repeat (n) push_beat(CMD_TICK, KEY_W'($urandom));
        end else if (pick < 8) begin
            repeat ($urandom_range(1, 4))
                push_beat(1'($urandom), KEY_W'($urandom));
        end else if (pick < 16) begin
            repeat (held) push_beat(CMD_KEY, pop_code);
            repeat ($urandom_range(0, N_DIGITS - 1)) push_digit($urandom_range(0, 9));
            push_beat(CMD_KEY, enter_code);
        end else if (pick < 22) begin
            repeat ($urandom_range(1, 6)) push_beat(CMD_TICK, KEY_W'($urandom));
        end else begin
            good = can_match && ((last_try && !may_lock) || $urandom_range(0, 99) >= miss_pct);
            repeat (held) push_beat(CMD_KEY, pop_code);
            for (int i = 0; i < N_DIGITS; i++) begin
                d = good ? sec_code[NIB_W*i +: NIB_W] : NIB_W'($urandom_range(0, 9));
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    push_digit($urandom_range(0, 9));
                    push_beat(CMD_KEY, pop_code);
                end else if (pick < 15 && (may_lock || !cd_running)) begin
                    // no ticks mid-entry while a cooldown could end into a wrong try
                    push_beat(CMD_TICK, KEY_W'($urandom));
                end else if (pick < 20) begin
                    push_beat(CMD_KEY, stray_key());
                end
                push_digit(d);
            end
            if ($urandom_range(0, 9) == 0)
                push_digit($urandom_range(0, 9));
            push_beat(CMD_KEY, enter_code);
        end
    endtask

    task automatic run_phase(input int n_items, input int miss_pct, input bit may_lock);
        int start;
        bit paused;
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < n_items) begin
            if (!paused && items_sent - start > n_items / 2) begin
                // hold off until the result side has caught up completely
                paused = 1'b1;
                wait_results();
            end else begin
                wait_sent();
            end
            push_round(miss_pct, may_lock);
        end
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] odd_secret;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: secret 0, pop '*', submit '#'
        push_beat(CMD_KEY, RST_VAL_KEY);
        push_beat(CMD_KEY, RST_POP_KEY);
        push_beat(CMD_KEY, 8'h00);
        push_beat(CMD_KEY, 8'hFF);
        push_beat(CMD_KEY, KEY_ZERO - 1'b1);
        push_beat(CMD_KEY, KEY_NINE + 1'b1);
        push_beat(CMD_TICK, 8'hFF);
        push_digit(9);
        repeat (5) push_digit(0);
        push_digit(5);
        push_beat(CMD_KEY, RST_VAL_KEY);
        repeat (6) push_digit(0);
        push_beat(CMD_KEY, RST_POP_KEY);
        push_digit(0);
        push_beat(CMD_KEY, RST_VAL_KEY);

        set_phase(32'h0099_9999, 8'd0, 8'd255, 4'd1, 32'd0);
        run_phase(350, 50, 1'b0);
        set_phase(rand_bcd(), 8'd255, 8'd0, 4'd15, 32'd1);
        run_phase(350, 95, 1'b0);
        set_phase(rand_bcd(), RST_POP_KEY, RST_VAL_KEY, 4'd0, 32'd5);
        run_phase(450, 100, 1'b0);
        odd_secret = rand_bcd();
        odd_secret[NIB_W*$urandom_range(0, SECRET_NIB - 1) +: NIB_W] =
            NIB_W'($urandom_range(10, 15));
        set_phase(odd_secret, KEY_ZERO + 8'd5, RST_VAL_KEY, 4'd15, 32'hFFFF_FFFF);
        run_phase(300, 100, 1'b0);
        // pop and submit share one code, so the shared code only pops
        set_phase(rand_bcd(), 8'h41, 8'h41, RST_MAX_MISS, RST_COOLDOWN);
        run_phase(100, 50, 1'b0);
        set_phase(rand_bcd(), RST_POP_KEY, RST_VAL_KEY, 4'd2, 32'd4);
        run_phase(350, 70, 1'b1);

        wait_results();
        repeat (8) @(negedge aclk);
        $display("sent %0d beats under %0d register settings, checked %0d results",
                 items_sent, phases + 1, checked);
        $display("answers ok %0d incomplete %0d invalid %0d valid %0d cooldown %0d reset %0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4], st_seen[5]);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/kpl_pkg.sv
design/keypad_passcode_lock_unit.sv
sim/tb_keypad_passcode_lock_unit.sv
